// File: hw/rtl/ps2_set1_scancode_decoder_macros.svh
// Assertion macros used by the scan code decoder top level
`ifndef PS2_SET1_SCANCODE_DECODER_MACROS_SVH
`define PS2_SET1_SCANCODE_DECODER_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define PS2S1_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the next clock edge
`define PS2S1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ps2s1_pkg.sv
// Constants, types and decode tables for the set 1 scan code decoder
package ps2s1_pkg;

    localparam int KEY_COUNT = 76;
    localparam int ADDR_W    = $clog2(KEY_COUNT);
    localparam int ID_W      = 7;

    localparam logic [7:0] CODE_PAUSE = 8'hE1;
    localparam logic [7:0] CODE_EXT   = 8'hE0;
    localparam logic [7:0] CODE_CAPS  = 8'h3A;
    localparam logic [7:0] CODE_NONE  = 8'h00;
    localparam logic [1:0] SKIP_PAUSE = 2'd2;

    // Decoded byte handed from the decode stage to the pipeline
    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] id;
        logic            rel;
        logic            caps;
    } dec_t;

    // Access request to the key-down store
    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
    } mem_req_t;

    // Plain (non-extended) make code to key number
    function automatic logic [ID_W-1:0] decode_make(input logic [6:0] c);
        logic [ID_W-1:0] id;
        id = '0;
        if (c inside {[7'h3B:7'h44]})
            id = c - 7'd57;
        else if (c inside {[7'h57:7'h58]})
            id = c - 7'd75;
        else if (c inside {[7'h02:7'h1B], [7'h1E:7'h28]})
            id = c + 7'd14;
        else if (c inside {[7'h2C:7'h36]})
            id = c + 7'd13;
        else begin
            case (c)
                7'h01:   id = 7'd1;
                7'h29:   id = 7'd15;
                7'h2B:   id = 7'd42;
                7'h3A:   id = 7'd43;
                7'h1C:   id = 7'd55;
                7'h2A:   id = 7'd56;
                7'h1D:   id = 7'd68;
                7'h38:   id = 7'd69;
                7'h39:   id = 7'd70;
                default: id = '0;
            endcase
        end
        return id;
    endfunction

    // Extended (after 0xE0) code to key number
    function automatic logic [ID_W-1:0] decode_ext(input logic [6:0] c);
        logic [ID_W-1:0] id;
        case (c)
            7'h1C:   id = 7'd55;
            7'h38:   id = 7'd71;
            7'h48:   id = 7'd73;
            7'h4B:   id = 7'd72;
            7'h4D:   id = 7'd75;
            7'h50:   id = 7'd74;
            7'h53:   id = 7'd14;
            default: id = '0;
        endcase
        return id;
    endfunction

endpackage

// File: hw/rtl/ps2s1_scan_if.sv
// Scan byte channel: valid/ready with one raw byte
interface ps2s1_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink (input valid, input scan_byte, output ready);
endinterface

// File: hw/rtl/ps2s1_key_if.sv
// Key event channel: valid/ready with the decoded key request
interface ps2s1_key_if;
    logic       valid;
    logic       ready;
    logic [6:0] key_id;
    logic       is_release;
    logic       caps_on;
    logic       was_held;
    logic       press_notify;

    modport source (output valid, output key_id, output is_release, output caps_on,
                    output was_held, output press_notify, input ready);
    modport sink (input valid, input key_id, input is_release, input caps_on,
                  input was_held, input press_notify, output ready);
endinterface

// File: hw/rtl/ps2_set1_scancode_decoder.sv
// Top level of the PS/2 scan code set 1 decoder
// Usage:
//   scan (sink): one raw set 1 byte per request. Zero bytes, 0xE0/0xE1
//   prefixes and the two bytes after 0xE1 are consumed without a result.
//   keys (source): one request per key byte with key id, release flag,
//   caps state, the key's previous held state and a press notify mark.
// Path: an accepted byte with a result is registered in the read stage
//   (decode plus key-store read), then moves into the output register when
//   the read stage retires, and keys can take it from there.
// Throughput: one byte per cycle while scan.ready is high; the key-store
//   read at acceptance and the same-cycle write-back of the previous key
//   byte are forwarded on the same key, so back-to-back bytes see each other.
// Reset: prefix, skip and caps state clear at once; the key-down store is
//   then swept to zero across all 76 entries, during which scan.ready stays low.
// Stall: when keys.ready is low the output register holds; one more byte
//   with a result can sit in the read stage, after which scan.ready drops
//   for every byte until the read stage moves on.
`include "ps2_set1_scancode_decoder_macros.svh"

module ps2_set1_scancode_decoder (
    input  logic               clk,
    input  logic               rst_n,
    ps2s1_scan_if.sink         scan,
    ps2s1_key_if.source        keys
);

    ps2s1_pkg::dec_t               dec;
    ps2s1_pkg::mem_req_t           mem_req;
    logic                          mem_rdata;
    logic                          mem_busy;
    logic                          take;
    logic                          s1_fire;
    logic                          held;

    logic                          s1_valid_reg, s1_valid_next;
    logic [ps2s1_pkg::ID_W-1:0]    s1_id_reg;
    logic                          s1_rel_reg;
    logic                          s1_caps_reg;
    logic                          s1_fwd_reg;
    logic                          s1_fwd_val_reg;

    logic                          out_valid_reg, out_valid_next;
    logic [ps2s1_pkg::ID_W-1:0]    out_id_reg;
    logic                          out_rel_reg;
    logic                          out_caps_reg;
    logic                          out_held_reg;

    // Handshake control
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || keys.ready);
    assign scan.ready = !mem_busy && (!s1_valid_reg || s1_fire);
    assign take       = scan.valid && scan.ready;

    ps2s1_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .scan_byte (scan.scan_byte),
        .dec       (dec)
    );

    // Read at acceptance, write back when the read stage retires
    always_comb
    begin
        mem_req       = '0;
        mem_req.re    = take && dec.hit;
        mem_req.raddr = dec.id[ps2s1_pkg::ADDR_W-1:0];
        mem_req.we    = s1_fire;
        mem_req.waddr = s1_id_reg[ps2s1_pkg::ADDR_W-1:0];
        mem_req.wdata = !s1_rel_reg;
    end

    ps2s1_key_mem u_key_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    // Read stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take && dec.hit)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Payload plus forward of a write to the same key in the same cycle
    always_ff @(posedge clk)
    begin
        if (take && dec.hit)
        begin
            s1_id_reg      <= dec.id;
            s1_rel_reg     <= dec.rel;
            s1_caps_reg    <= dec.caps;
            s1_fwd_reg     <= s1_fire && (s1_id_reg == dec.id);
            s1_fwd_val_reg <= !s1_rel_reg;
        end
    end

    assign held = s1_fwd_reg ? s1_fwd_val_reg : mem_rdata;

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire)
            out_valid_next = 1'b1;
        else if (keys.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_id_reg   <= s1_id_reg;
            out_rel_reg  <= s1_rel_reg;
            out_caps_reg <= s1_caps_reg;
            out_held_reg <= held;
        end
    end

    assign keys.valid        = out_valid_reg;
    assign keys.key_id       = out_id_reg;
    assign keys.is_release   = out_rel_reg;
    assign keys.caps_on      = out_caps_reg;
    assign keys.was_held     = out_held_reg;
    assign keys.press_notify = !out_rel_reg;

    // Checks
    `PS2S1_ASSERT(a_no_read_on_stall, clk, rst_n,
        !(s1_valid_reg && !s1_fire && mem_req.re),
        "key store read issued while read stage is stalled")
    `PS2S1_ASSERT(a_undef_is_release, clk, rst_n,
        !(s1_valid_reg && s1_id_reg == '0 && !s1_rel_reg),
        "undefined key reported as a press")
    `PS2S1_ASSERT(a_empty_while_clearing, clk, rst_n,
        !(mem_busy && (s1_valid_reg || out_valid_reg)),
        "request in flight during key store clear")
    `PS2S1_ASSERT_NEXT(a_out_loaded, clk, rst_n, s1_fire, out_valid_reg,
        "retired request did not reach the output register")

endmodule

// File: hw/rtl/ps2s1_decode.sv
// Prefix/skip/caps tracking and table decode of one scan byte
module ps2s1_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         scan_byte,
    output ps2s1_pkg::dec_t    dec
);

    logic       ext_reg, ext_next;
    logic [1:0] skip_reg, skip_next;
    logic       caps_reg, caps_next;

    // Sequence tracking and table lookup
    always_comb
    begin
        ext_next  = ext_reg;
        skip_next = skip_reg;
        caps_next = caps_reg;
        dec       = '0;
        if (take && scan_byte != ps2s1_pkg::CODE_NONE)
        begin
            if (skip_reg != 2'd0)
                skip_next = skip_reg - 2'd1;
            else if (scan_byte == ps2s1_pkg::CODE_PAUSE)
                skip_next = ps2s1_pkg::SKIP_PAUSE;
            else if (scan_byte == ps2s1_pkg::CODE_EXT)
                ext_next = 1'b1;
            else
            begin
                dec.hit  = 1'b1;
                ext_next = 1'b0;
                if (ext_reg)
                    dec.id = ps2s1_pkg::decode_ext(scan_byte[6:0]);
                else
                begin
                    dec.id = ps2s1_pkg::decode_make(scan_byte[6:0]);
                    if (scan_byte == ps2s1_pkg::CODE_CAPS)
                        caps_next = ~caps_reg;
                end
                // undefined codes always report as a release
                dec.rel = scan_byte[7] || (dec.id == '0);
            end
        end
        dec.caps = caps_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg  <= 1'b0;
            skip_reg <= 2'd0;
            caps_reg <= 1'b0;
        end
        else
        begin
            ext_reg  <= ext_next;
            skip_reg <= skip_next;
            caps_reg <= caps_next;
        end
    end

endmodule

// File: hw/rtl/ps2s1_key_mem.sv
// Key-down store: one-bit synchronous RAM with a clearing sweep after reset
module ps2s1_key_mem (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ps2s1_pkg::mem_req_t  req,
    output logic                 rdata,
    output logic                 busy
);

    localparam logic [ps2s1_pkg::ADDR_W-1:0] LAST_ADDR =
        ps2s1_pkg::ADDR_W'(ps2s1_pkg::KEY_COUNT - 1);

    logic                          mem [ps2s1_pkg::KEY_COUNT];
    logic [ps2s1_pkg::ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                          busy_reg, busy_next;
    logic                          rdata_reg;
    logic                          we;
    logic [ps2s1_pkg::ADDR_W-1:0]  waddr;
    logic                          wdata;

    // Clearing sweep, one entry per cycle
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + ps2s1_pkg::ADDR_W'(1);
            if (clr_cnt_reg == LAST_ADDR)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    // Write port shared by the sweep and the pipeline
    assign we    = busy_reg | req.we;
    assign waddr = busy_reg ? clr_cnt_reg : req.waddr;
    assign wdata = busy_reg ? 1'b0 : req.wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (req.re)
            rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule
